// ===== hw/rtl/tlv_frame_receiver_assert.svh =====
// assertion macros for the tlv frame receiver
// expects clk and rst in the scope where a macro is used
`ifndef TLV_FRAME_RECEIVER_ASSERT_SVH
`define TLV_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, off during reset
`define TLVR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlvr same-cycle check failed");

// next-cycle implication, off during reset
`define TLVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlvr next-cycle check failed");

`endif

// ===== hw/rtl/tlvr_pkg.sv =====
// shared types and constants for the tlv frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlvr_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd2;

  localparam logic [15:0] RST_MY_ADDRESS = 16'h0000;
  localparam logic [15:0] RST_BCAST_ADDRESS = 16'hFFFF;
  localparam logic [15:0] RST_MAX_FRAME_BYTES = 16'd256;

  // parameter type characters
  localparam logic [7:0] TYPE_CHAR = 8'h63;      // c
  localparam logic [7:0] TYPE_BYTE_U = 8'h42;    // B
  localparam logic [7:0] TYPE_BYTE_S = 8'h62;    // b
  localparam logic [7:0] TYPE_INT_S = 8'h69;     // i
  localparam logic [7:0] TYPE_INT_U = 8'h49;     // I
  localparam logic [7:0] TYPE_LONG_S = 8'h6C;    // l
  localparam logic [7:0] TYPE_LONG_U = 8'h4C;    // L
  localparam logic [7:0] TYPE_STR8 = 8'h73;      // s
  localparam logic [7:0] TYPE_STRUCT8 = 8'h74;   // t
  localparam logic [7:0] TYPE_STR16 = 8'h53;     // S
  localparam logic [7:0] TYPE_STRUCT16 = 8'h54;  // T

  // parameter names that are tracked
  localparam logic [7:0] NAME_SUBJECT = 8'h73;   // s
  localparam logic [7:0] NAME_COMMAND = 8'h63;   // c

  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  param_name;
    logic [7:0]  param_type;
    logic [31:0] param_value;
    logic [15:0] payload_length;
    logic        frame_valid;
    logic        for_me;
    logic        type_error;
    logic [15:0] sender_address;
    logic [7:0]  subject_char;
    logic [7:0]  command_char;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlvr_in_reg.sv =====
// input register stage of the tlv frame receiver
// depends on tlvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlvr_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,
  input  wire logic               s_axis_tuser,
  input  wire logic               consume,
  output logic                    item_valid,
  output tlvr_pkg::in_item_t      item
);
  import tlvr_pkg::*;

  // a held byte leaves in the same cycle it is parsed, so a new one can enter
  assign s_axis_tready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.rx_byte <= s_axis_tdata;
      item.frame_start <= s_axis_tuser;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlvr_parser.sv =====
// frame parser: holds the per-frame state and configuration registers,
// steps once per byte and produces at most one result. depends on tlvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlvr_parser (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tlvr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [tlvr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               step,
  input  wire tlvr_pkg::in_item_t                 item,
  output logic                                    res_load,
  output tlvr_pkg::result_t                       res
);
  import tlvr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LENLO, PH_TLEN, PH_TARGET, PH_SLEN, PH_SOURCE, PH_PCOUNT,
    PH_PNAME, PH_PTYPE, PH_PVALUE, PH_PLEN, PH_PAYLOAD, PH_DRAIN
  } phase_t;

  logic [15:0] my_address;
  logic [15:0] bcast_address;
  logic [15:0] max_frame_bytes;

  phase_t      phase, phase_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] field_remaining, field_remaining_next;
  logic [7:0]  target_length, target_length_next;
  logic [15:0] target_word, target_word_next;
  logic [15:0] source_word, source_word_next;
  logic [7:0]  params_left, params_left_next;
  logic [7:0]  current_name, current_name_next;
  logic [7:0]  current_type, current_type_next;
  logic [31:0] value_acc, value_acc_next;
  logic [15:0] payload_len, payload_len_next;
  logic        subject_found, subject_found_next;
  logic [7:0]  subject_val, subject_val_next;
  logic        command_found, command_found_next;
  logic [7:0]  command_val, command_val_next;
  logic        type_error_flag, type_error_flag_next;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] idx;
    logic [16:0] src;
    logic        finish;
    logic        fixed;
    logic        claim_en;
    logic [7:0]  claim_v;
    logic        valid;

    b = item.rx_byte;
    idx = byte_index + 16'd1;
    src = 17'd4 + {9'd0, target_length};
    finish = 1'b0;
    fixed = 1'b0;
    claim_en = 1'b0;
    claim_v = 8'd0;
    valid = 1'b0;

    phase_next = phase;
    byte_index_next = byte_index;
    frame_length_next = frame_length;
    running_sum_next = running_sum;
    field_remaining_next = field_remaining;
    target_length_next = target_length;
    target_word_next = target_word;
    source_word_next = source_word;
    params_left_next = params_left;
    current_name_next = current_name;
    current_type_next = current_type;
    value_acc_next = value_acc;
    payload_len_next = payload_len;
    subject_found_next = subject_found;
    subject_val_next = subject_val;
    command_found_next = command_found;
    command_val_next = command_val;
    type_error_flag_next = type_error_flag;
    res_load = 1'b0;
    res = '0;

    if (!step) begin
      // hold
    end else if (item.frame_start) begin
      // resync: drop any open frame
      phase_next = PH_LENLO;
      byte_index_next = '0;
      frame_length_next = {b, 8'd0};
      running_sum_next = b;
      field_remaining_next = '0;
      target_length_next = '0;
      target_word_next = '0;
      source_word_next = '0;
      params_left_next = '0;
      current_name_next = '0;
      current_type_next = '0;
      value_acc_next = '0;
      payload_len_next = '0;
      subject_found_next = 1'b0;
      subject_val_next = '0;
      command_found_next = 1'b0;
      command_val_next = '0;
      type_error_flag_next = 1'b0;
    end else if (phase != PH_IDLE) begin
      byte_index_next = idx;
      if (phase == PH_LENLO) begin
        frame_length_next = frame_length | {8'd0, b};
        running_sum_next = running_sum + b;
        phase_next = PH_TLEN;
      end else if (idx >= 16'd2 && ({1'b0, idx} + 17'd1) >= {1'b0, frame_length}) begin
        // checksum byte ends the frame wherever the parser stands
        valid = frame_length >= 16'd3 && frame_length < max_frame_bytes &&
                running_sum == b;
        res_load = 1'b1;
        res.result_kind = KIND_FRAME;
        res.frame_valid = valid;
        res.for_me = valid && (target_word == bcast_address ||
                     (target_length == 8'd2 && target_word == my_address));
        res.type_error = type_error_flag;
        res.sender_address = source_word;
        res.subject_char = subject_val;
        res.command_char = command_val;
        phase_next = PH_IDLE;
      end else begin
        running_sum_next = running_sum + b;
        if (idx == 16'd3) begin
          target_word_next[15:8] = b;
        end else if (idx == 16'd4) begin
          target_word_next[7:0] = b;
        end
        if ({1'b0, idx} == src) begin
          source_word_next[15:8] = b;
        end else if ({1'b0, idx} == src + 17'd1) begin
          source_word_next[7:0] = b;
        end

        case (phase)
          PH_TLEN: begin
            target_length_next = b;
            field_remaining_next = {8'd0, b};
            phase_next = (b != 8'd0) ? PH_TARGET : PH_SLEN;
          end
          PH_TARGET: begin
            field_remaining_next = field_remaining - 16'd1;
            if (field_remaining_next == 16'd0) phase_next = PH_SLEN;
          end
          PH_SLEN: begin
            field_remaining_next = {8'd0, b};
            phase_next = (b != 8'd0) ? PH_SOURCE : PH_PCOUNT;
          end
          PH_SOURCE: begin
            field_remaining_next = field_remaining - 16'd1;
            if (field_remaining_next == 16'd0) phase_next = PH_PCOUNT;
          end
          PH_PCOUNT: begin
            params_left_next = b;
            phase_next = (b != 8'd0) ? PH_PNAME : PH_DRAIN;
          end
          PH_PNAME: begin
            current_name_next = b;
            phase_next = PH_PTYPE;
          end
          PH_PTYPE: begin
            current_type_next = b;
            value_acc_next = '0;
            payload_len_next = '0;
            if (b inside {TYPE_CHAR, TYPE_BYTE_U, TYPE_BYTE_S}) begin
              field_remaining_next = 16'd1;
              phase_next = PH_PVALUE;
            end else if (b inside {TYPE_INT_S, TYPE_INT_U}) begin
              field_remaining_next = 16'd2;
              phase_next = PH_PVALUE;
            end else if (b inside {TYPE_LONG_S, TYPE_LONG_U}) begin
              field_remaining_next = 16'd4;
              phase_next = PH_PVALUE;
            end else if (b inside {TYPE_STR8, TYPE_STRUCT8}) begin
              field_remaining_next = 16'd1;
              phase_next = PH_PLEN;
            end else if (b inside {TYPE_STR16, TYPE_STRUCT16}) begin
              field_remaining_next = 16'd2;
              phase_next = PH_PLEN;
            end else begin
              // unknown type: stop parsing, name still claims with zero value
              type_error_flag_next = 1'b1;
              claim_en = 1'b1;
              phase_next = PH_DRAIN;
            end
          end
          PH_PVALUE: begin
            value_acc_next = {value_acc[23:0], b};
            field_remaining_next = field_remaining - 16'd1;
            if (field_remaining_next == 16'd0) begin
              finish = 1'b1;
              fixed = 1'b1;
            end
          end
          PH_PLEN: begin
            payload_len_next = {payload_len[7:0], b};
            field_remaining_next = field_remaining - 16'd1;
            if (field_remaining_next == 16'd0) begin
              if (payload_len_next == 16'd0) begin
                finish = 1'b1;
              end else begin
                field_remaining_next = payload_len_next;
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            field_remaining_next = field_remaining - 16'd1;
            if (field_remaining_next == 16'd0) finish = 1'b1;
          end
          default: begin
          end
        endcase

        if (finish) begin
          res_load = 1'b1;
          res.result_kind = KIND_PARAM;
          res.param_name = current_name;
          res.param_type = current_type;
          res.param_value = fixed ? value_acc_next : 32'd0;
          res.payload_length = fixed ? 16'd0 : payload_len_next;
          claim_en = 1'b1;
          claim_v = value_acc_next[7:0];
          params_left_next = params_left - 8'd1;
          phase_next = (params_left_next != 8'd0) ? PH_PNAME : PH_DRAIN;
        end

        // first parameter named s or c wins; value only counts for char type
        if (claim_en) begin
          if (current_type_next != TYPE_CHAR) claim_v = 8'd0;
          if (current_name_next == NAME_SUBJECT && !subject_found) begin
            subject_found_next = 1'b1;
            subject_val_next = claim_v;
          end
          if (current_name_next == NAME_COMMAND && !command_found) begin
            command_found_next = 1'b1;
            command_val_next = claim_v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      my_address <= RST_MY_ADDRESS;
      bcast_address <= RST_BCAST_ADDRESS;
      max_frame_bytes <= RST_MAX_FRAME_BYTES;
      phase <= PH_IDLE;
      byte_index <= '0;
      frame_length <= '0;
      running_sum <= '0;
      field_remaining <= '0;
      target_length <= '0;
      target_word <= '0;
      source_word <= '0;
      params_left <= '0;
      current_name <= '0;
      current_type <= '0;
      value_acc <= '0;
      payload_len <= '0;
      subject_found <= 1'b0;
      subject_val <= '0;
      command_found <= 1'b0;
      command_val <= '0;
      type_error_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MY_ADDRESS:      my_address <= cfg_wdata;
          CFG_BCAST_ADDRESS:   bcast_address <= cfg_wdata;
          CFG_MAX_FRAME_BYTES: max_frame_bytes <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase <= phase_next;
      byte_index <= byte_index_next;
      frame_length <= frame_length_next;
      running_sum <= running_sum_next;
      field_remaining <= field_remaining_next;
      target_length <= target_length_next;
      target_word <= target_word_next;
      source_word <= source_word_next;
      params_left <= params_left_next;
      current_name <= current_name_next;
      current_type <= current_type_next;
      value_acc <= value_acc_next;
      payload_len <= payload_len_next;
      subject_found <= subject_found_next;
      subject_val <= subject_val_next;
      command_found <= command_found_next;
      command_val <= command_val_next;
      type_error_flag <= type_error_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlvr_out_reg.sv =====
// result register and master-side stream driver of the tlv frame receiver
// depends on tlvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlvr_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire tlvr_pkg::result_t                 res,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [tlvr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser
);
  import tlvr_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tuser = held.result_kind;
  assign m_axis_tdata = {5'd0, held.command_char, held.subject_char,
                         held.sender_address, held.type_error, held.for_me,
                         held.frame_valid, held.payload_length, held.param_value,
                         held.param_type, held.param_name};

endmodule

`default_nettype wire

// ===== hw/rtl/tlv_frame_receiver.sv =====
// tlv frame receiver: byte-serial parser for length-prefixed frames with
// typed parameters and an 8-bit additive checksum.
//
// usage:
//   s_axis: one frame byte per transaction; tuser high marks byte 0 of a
//     frame and restarts the parser, dropping any open frame without a result.
//   m_axis: one result per finished parameter (tuser 0) and one at the
//     checksum byte (tuser 1) with validity, addressing, sender, subject and
//     command. bytes that finish nothing produce no transaction.
//   cfg: cfg_we writes cfg_wdata to register cfg_addr (0 my address,
//     1 broadcast address, 2 max frame bytes); write only while idle.
// path: an input transaction reaches m_axis_tvalid through the input
//   register, then the parse step that loads the result register.
// throughput: 1 byte per cycle while no result waits on m_axis_tready.
// stall: while a result waits on m_axis_tready the parser holds one byte in
//   its input register and deasserts s_axis_tready only when that byte is held.
// reset: rst (synchronous) empties both registers, sets the parser idle and
//   restores the register defaults (0, 0xFFFF, 256).
`timescale 1ns / 1ps
`default_nettype none
`include "tlv_frame_receiver_assert.svh"

module tlv_frame_receiver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] rx_byte
  input  wire logic [7:0]                        s_axis_tdata,
  // [0] frame_start
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] param_name, [15:8] param_type, [47:16] param_value,
  // [63:48] payload_length, [64] frame_valid, [65] for_me, [66] type_error,
  // [82:67] sender_address, [90:83] subject_char, [98:91] command_char
  output logic [tlvr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // [0] result_kind
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [tlvr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [tlvr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tlvr_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     consume;
  logic     res_load;
  result_t  res;

  // parse only when the result register is free or being emptied
  assign consume = item_valid && (!m_axis_tvalid || m_axis_tready);

  tlvr_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .consume      (consume),
    .item_valid   (item_valid),
    .item         (item)
  );

  tlvr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .step     (consume),
    .item     (item),
    .res_load (res_load),
    .res      (res)
  );

  tlvr_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (res_load),
    .res          (res),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // a new result never overwrites one that is still waiting
  `TLVR_ASSERT_IMPL(a_no_overwrite, res_load && m_axis_tvalid, m_axis_tready)
  // a loaded result is presented in the next cycle
  `TLVR_ASSERT_NEXT(a_load_shows, res_load, m_axis_tvalid)
  // a byte entering a full input register must displace one being parsed
  `TLVR_ASSERT_IMPL(a_in_reg_safe, s_axis_tvalid && s_axis_tready && item_valid, consume)

endmodule

`default_nettype wire
